>>> design/ssp_pkg.sv
// Shared constants, types and helper functions for the sprite projection pipeline.
package ssp_pkg;

   // Texture edge length in texels and its Q8.16 numerator for the step divide
   localparam int TEX_SIZE = 64;
   localparam int TEX_Q16  = TEX_SIZE * 65536;

   // Smallest lateral value, 0.001 in Q16.16
   localparam logic signed [31:0] LAT_MIN_Q16 = 32'sd66;

   // Divider geometry: dividend, divisor and quotient widths
   localparam int NUM_W  = 64;
   localparam int DEN_W  = 40;
   localparam int QUO_W  = 33;
   localparam int TRY_W  = DEN_W + QUO_W;
   localparam int SIDE_W = 160;

   // Configuration register indexes
   localparam logic [2:0] CSR_PLAYER_X    = 3'd0;
   localparam logic [2:0] CSR_PLAYER_Y    = 3'd1;
   localparam logic [2:0] CSR_VIEW_DIR_X  = 3'd2;
   localparam logic [2:0] CSR_VIEW_DIR_Y  = 3'd3;
   localparam logic [2:0] CSR_CAM_PLANE_X = 3'd4;
   localparam logic [2:0] CSR_CAM_PLANE_Y = 3'd5;
   localparam logic [2:0] CSR_SCREEN_W    = 3'd6;
   localparam logic [2:0] CSR_SCREEN_H    = 3'd7;

   typedef struct packed {
      logic        [23:0] player_x;
      logic        [23:0] player_y;
      logic signed [17:0] view_dir_x;
      logic signed [17:0] view_dir_y;
      logic signed [17:0] cam_plane_x;
      logic signed [17:0] cam_plane_y;
      logic        [12:0] screen_width;
      logic        [12:0] screen_height;
   } ssp_cfg_type;

   // Front end result handed to the camera space dividers
   typedef struct packed {
      logic             valid;
      logic [NUM_W-1:0] lat_num;
      logic [NUM_W-1:0] dep_num;
      logic [DEN_W-1:0] det_mag;
      logic             lat_neg;
      logic             dep_neg;
      logic             det_zero;
   } ssp_front_type;

   // One stage of the restoring divider
   typedef struct packed {
      logic              valid;
      logic [NUM_W-1:0]  rem;
      logic [DEN_W-1:0]  den;
      logic [QUO_W-1:0]  quo;
      logic              ovf;
      logic [SIDE_W-1:0] side;
   } ssp_div_stage_type;

   // Side data carried by each divider chain
   typedef struct packed {
      logic lat_neg;
      logic dep_neg;
      logic det_zero;
   } ssp_sb1_type;

   typedef struct packed {
      logic signed [31:0] lat;
      logic signed [31:0] dep;
      logic               det_zero;
      logic               dep_zero;
      logic               c_neg;
   } ssp_sb2_type;

   typedef struct packed {
      logic signed [31:0] lat;
      logic signed [31:0] dep;
      logic               det_zero;
      logic               dep_zero;
      logic signed [20:0] center;
      logic        [15:0] side;
      logic signed [20:0] first;
      logic signed [20:0] last;
   } ssp_sb3_type;

   // Turn a quotient magnitude into a saturated signed 32-bit value
   function automatic logic signed [31:0] sat_quo32(input logic [QUO_W-1:0] q,
                                                    input logic ovf, input logic neg);
      logic signed [31:0] r;
      if (neg) begin
         if (ovf || q > 33'h080000000) r = 32'sh80000000;
         else                          r = 32'(~q[31:0] + 32'd1);
      end else begin
         if (ovf || q[32:31] != 2'b00) r = 32'sh7fffffff;
         else                          r = 32'(q[31:0]);
      end
      return r;
   endfunction

   // Clamp a signed value to the 21-bit column range
   function automatic logic signed [20:0] clamp21(input logic signed [32:0] v);
      logic signed [20:0] r;
      if (v > 33'sd1048575)       r = 21'sd1048575;
      else if (v < -33'sd1048576) r = -21'sd1048576;
      else                        r = 21'(v);
      return r;
   endfunction

endpackage

>>> design/ssp_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side data.
module ssp_div import ssp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_quo,
   output logic              out_ovf,
   output logic [SIDE_W-1:0] out_side
);

   ssp_div_stage_type stage_ff [QUO_W+1];
   ssp_div_stage_type stage_in [QUO_W+1];

   // Load: flag a quotient that does not fit in QUO_W bits
   always_comb begin
      stage_in[0].valid = in_valid;
      stage_in[0].rem   = in_num;
      stage_in[0].den   = in_den;
      stage_in[0].quo   = '0;
      stage_in[0].ovf   = {{(TRY_W-NUM_W){1'b0}}, in_num} >= {in_den, {QUO_W{1'b0}}};
      stage_in[0].side  = in_side;
   end

   // Each stage tries one shifted divisor, most significant bit first
   for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
      localparam int BIT = QUO_W - k;
      logic [TRY_W-1:0] shifted;
      logic [TRY_W-1:0] rem_ext;
      logic             take;
      always_comb begin
         shifted  = {{QUO_W{1'b0}}, stage_ff[k-1].den} << BIT;
         rem_ext  = {{(TRY_W-NUM_W){1'b0}}, stage_ff[k-1].rem};
         take     = rem_ext >= shifted;
         stage_in[k] = stage_ff[k-1];
         stage_in[k].rem = take ? NUM_W'(rem_ext - shifted) : stage_ff[k-1].rem;
         stage_in[k].quo[BIT] = take;
      end
   end

   // Advance all stages together
   for (genvar k = 0; k <= QUO_W; k++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[k].valid <= 1'b0;
         end else if (adv) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign out_valid = stage_ff[QUO_W].valid;
   assign out_quo   = stage_ff[QUO_W].quo;
   assign out_ovf   = stage_ff[QUO_W].ovf;
   assign out_side  = stage_ff[QUO_W].side;

endmodule

>>> design/ssp_front.sv
// Front end: viewer-relative offset, matrix products and divide operands.
module ssp_front import ssp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  ssp_cfg_type   cfg,
   input  logic          req_valid,
   input  logic [23:0]   req_sprite_x,
   input  logic [23:0]   req_sprite_y,
   output ssp_front_type front_out
);

   logic               v1_ff, v2_ff, v3_ff;
   logic signed [24:0] dx_ff, dy_ff, dx_in, dy_in;
   logic signed [42:0] pa_ff, pb_ff, pc_ff, pd_ff, pa_in, pb_in, pc_in, pd_in;
   logic signed [35:0] da_ff, db_ff, da_in, db_in;
   logic signed [43:0] lat_num_ff, dep_num_ff, lat_num_in, dep_num_in;
   logic signed [36:0] det_ff, det_in;
   logic        [43:0] lat_mag, dep_mag;
   logic        [36:0] det_mag;
   ssp_front_type      front_ff, front_in;

   // Offset from the viewer
   assign dx_in = $signed({1'b0, req_sprite_x}) - $signed({1'b0, cfg.player_x});
   assign dy_in = $signed({1'b0, req_sprite_y}) - $signed({1'b0, cfg.player_y});

   // Matrix products
   assign pa_in = dx_ff * cfg.view_dir_y;
   assign pb_in = dy_ff * cfg.view_dir_x;
   assign pc_in = dy_ff * cfg.cam_plane_x;
   assign pd_in = dx_ff * cfg.cam_plane_y;
   assign da_in = cfg.cam_plane_x * cfg.view_dir_y;
   assign db_in = cfg.view_dir_x * cfg.cam_plane_y;

   // Differences
   assign lat_num_in = 44'(pa_ff) - 44'(pb_ff);
   assign dep_num_in = 44'(pc_ff) - 44'(pd_ff);
   assign det_in     = 37'(da_ff) - 37'(db_ff);

   // Magnitudes and signs for the unsigned dividers
   always_comb begin
      lat_mag = lat_num_ff[43] ? 44'(-lat_num_ff) : 44'(lat_num_ff);
      dep_mag = dep_num_ff[43] ? 44'(-dep_num_ff) : 44'(dep_num_ff);
      det_mag = det_ff[36] ? 37'(-det_ff) : 37'(det_ff);
      front_in.valid    = v3_ff;
      front_in.lat_num  = NUM_W'({lat_mag, 16'h0000});
      front_in.dep_num  = NUM_W'({dep_mag, 16'h0000});
      front_in.det_mag  = DEN_W'(det_mag);
      front_in.lat_neg  = lat_num_ff[43] ^ det_ff[36];
      front_in.dep_neg  = dep_num_ff[43] ^ det_ff[36];
      front_in.det_zero = det_ff == 37'sd0;
   end

   // Hold valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         v3_ff          <= 1'b0;
         front_ff.valid <= 1'b0;
      end else if (adv) begin
         v1_ff    <= req_valid;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         front_ff <= front_in;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff      <= dx_in;
         dy_ff      <= dy_in;
         pa_ff      <= pa_in;
         pb_ff      <= pb_in;
         pc_ff      <= pc_in;
         pd_ff      <= pd_in;
         da_ff      <= da_in;
         db_ff      <= db_in;
         lat_num_ff <= lat_num_in;
         dep_num_ff <= dep_num_in;
         det_ff     <= det_in;
      end
   end

   assign front_out = front_ff;

endmodule

>>> design/sprite_screen_projection_top.sv
// Sprite projection top level: configuration registers, pipeline and result register.
//
// Projects one sprite world position per transfer into camera space and screen columns.
// Request channel: req_valid with req_sprite_x/req_sprite_y, req_stall back-pressure.
// Result channel: rsp_valid with one result item per request, rsp_stall from the sink.
// Configuration: csr_wr_en, csr_index, csr_wdata; write only while the pipeline is empty.
// Pipeline: three chained 34-stage dividers (camera space, center and side length,
// texture step) plus front end and glue stages lie between request transfer and
// rsp_valid.
// Throughput: one item per cycle while the sink does not stall.
// The whole pipeline moves with one enable; a stalled result freezes every stage
// and raises req_stall, so nothing is lost or repeated, and the result register
// keeps its payload until taken.
// Reset (synchronous) clears all valid bits and loads the register defaults:
// view direction (1,0), camera plane (0,0.66667), window 640 by 480.
// A zero determinant or depth sets rsp_invalid and zeroes the dependent fields.
module sprite_screen_projection_top import ssp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [23:0]        req_sprite_x,
   input  logic [23:0]        req_sprite_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_cam_lateral,
   output logic signed [31:0] rsp_cam_depth,
   output logic signed [20:0] rsp_center_col,
   output logic        [15:0] rsp_side_length,
   output logic signed [20:0] rsp_first_col,
   output logic signed [20:0] rsp_last_col,
   output logic        [23:0] rsp_texel_step,
   output logic               rsp_invalid,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_wdata
);

   ssp_cfg_type   cfg_ff;
   ssp_front_type front;
   logic          adv;
   logic          rsp_valid_ff;

   // Global advance: move when the result register is empty or being taken
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.player_x      <= 24'd0;
         cfg_ff.player_y      <= 24'd0;
         cfg_ff.view_dir_x    <= 18'sd65536;
         cfg_ff.view_dir_y    <= 18'sd0;
         cfg_ff.cam_plane_x   <= 18'sd0;
         cfg_ff.cam_plane_y   <= 18'sd43691;
         cfg_ff.screen_width  <= 13'd640;
         cfg_ff.screen_height <= 13'd480;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PLAYER_X:    cfg_ff.player_x      <= csr_wdata;
            CSR_PLAYER_Y:    cfg_ff.player_y      <= csr_wdata;
            CSR_VIEW_DIR_X:  cfg_ff.view_dir_x    <= csr_wdata[17:0];
            CSR_VIEW_DIR_Y:  cfg_ff.view_dir_y    <= csr_wdata[17:0];
            CSR_CAM_PLANE_X: cfg_ff.cam_plane_x   <= csr_wdata[17:0];
            CSR_CAM_PLANE_Y: cfg_ff.cam_plane_y   <= csr_wdata[17:0];
            CSR_SCREEN_W:    cfg_ff.screen_width  <= csr_wdata[12:0];
            CSR_SCREEN_H:    cfg_ff.screen_height <= csr_wdata[12:0];
            default:         cfg_ff.player_x      <= cfg_ff.player_x;
         endcase
      end
   end

   ssp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .cfg          (cfg_ff),
      .req_valid    (req_valid),
      .req_sprite_x (req_sprite_x),
      .req_sprite_y (req_sprite_y),
      .front_out    (front)
   );

   // Camera space divides: lateral and depth share the determinant
   ssp_sb1_type       sb1_in, sb1_out;
   logic              d1_valid, d1_lat_ovf, d1_dep_ovf;
   logic [QUO_W-1:0]  d1_lat_q, d1_dep_q;
   logic [SIDE_W-1:0] d1_side;

   always_comb begin
      sb1_in.lat_neg  = front.lat_neg;
      sb1_in.dep_neg  = front.dep_neg;
      sb1_in.det_zero = front.det_zero;
   end

   ssp_div u_div_lat (
      .clock (clock), .reset (reset), .adv (adv),
      .in_valid (front.valid), .in_num (front.lat_num), .in_den (front.det_mag),
      .in_side (SIDE_W'(sb1_in)),
      .out_valid (d1_valid), .out_quo (d1_lat_q), .out_ovf (d1_lat_ovf), .out_side (d1_side)
   );

   ssp_div u_div_dep (
      .clock (clock), .reset (reset), .adv (adv),
      .in_valid (front.valid), .in_num (front.dep_num), .in_den (front.det_mag),
      .in_side ({SIDE_W{1'b0}}),
      .out_valid (), .out_quo (d1_dep_q), .out_ovf (d1_dep_ovf), .out_side ()
   );

   assign sb1_out = ssp_sb1_type'(d1_side[$bits(ssp_sb1_type)-1:0]);

   // Saturate lateral and depth, lift a zero lateral
   logic               v5_ff, v6_ff;
   logic signed [31:0] lat5_ff, dep5_ff, lat5_in, dep5_in;
   logic               dz5_ff, ez5_ff;
   logic signed [31:0] lat6_ff, dep6_ff;
   logic               dz6_ff, ez6_ff;
   logic signed [45:0] prod6_ff, prod6_in;
   logic        [31:0] adep6_ff, adep6_in;

   always_comb begin
      lat5_in = sat_quo32(d1_lat_q, d1_lat_ovf, sb1_out.lat_neg);
      dep5_in = sat_quo32(d1_dep_q, d1_dep_ovf, sb1_out.dep_neg);
      if (lat5_in == 32'sd0) lat5_in = LAT_MIN_Q16;
   end

   // Center numerator (depth + lateral) * half width and depth magnitude
   assign prod6_in = (33'(lat5_ff) + 33'(dep5_ff)) * $signed({1'b0, cfg_ff.screen_width[12:1]});
   assign adep6_in = dep5_ff[31] ? 32'(-dep5_ff) : 32'(dep5_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= d1_valid;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lat5_ff  <= lat5_in;
         dep5_ff  <= dep5_in;
         dz5_ff   <= sb1_out.det_zero;
         ez5_ff   <= dep5_in == 32'sd0;
         lat6_ff  <= lat5_ff;
         dep6_ff  <= dep5_ff;
         dz6_ff   <= dz5_ff;
         ez6_ff   <= ez5_ff;
         prod6_ff <= prod6_in;
         adep6_ff <= adep6_in;
      end
   end

   // Center column and side length divides
   ssp_sb2_type       sb2_in, sb2_out;
   logic [45:0]       cmag;
   logic              d2_valid, d2_c_ovf, d2_s_ovf;
   logic [QUO_W-1:0]  d2_c_q, d2_s_q;
   logic [SIDE_W-1:0] d2_side;

   always_comb begin
      cmag = prod6_ff[45] ? 46'(-prod6_ff) : 46'(prod6_ff);
      sb2_in.lat      = lat6_ff;
      sb2_in.dep      = dep6_ff;
      sb2_in.det_zero = dz6_ff;
      sb2_in.dep_zero = ez6_ff;
      sb2_in.c_neg    = prod6_ff[45] ^ dep6_ff[31];
   end

   ssp_div u_div_center (
      .clock (clock), .reset (reset), .adv (adv),
      .in_valid (v6_ff), .in_num (NUM_W'(cmag)), .in_den (DEN_W'(adep6_ff)),
      .in_side (SIDE_W'(sb2_in)),
      .out_valid (d2_valid), .out_quo (d2_c_q), .out_ovf (d2_c_ovf), .out_side (d2_side)
   );

   ssp_div u_div_side (
      .clock (clock), .reset (reset), .adv (adv),
      .in_valid (v6_ff), .in_num (NUM_W'({cfg_ff.screen_height, 16'h0000})),
      .in_den (DEN_W'({adep6_ff, 1'b0})),
      .in_side ({SIDE_W{1'b0}}),
      .out_valid (), .out_quo (d2_s_q), .out_ovf (d2_s_ovf), .out_side ()
   );

   assign sb2_out = ssp_sb2_type'(d2_side[$bits(ssp_sb2_type)-1:0]);

   // Saturate center and even side length
   logic               v8_ff;
   ssp_sb3_type        sb3_ff, sb3_in;
   ssp_sb3_type        sb3_out;
   logic signed [31:0] center32;

   always_comb begin
      center32         = sat_quo32(d2_c_q, d2_c_ovf, sb2_out.c_neg);
      sb3_in.lat       = sb2_out.lat;
      sb3_in.dep       = sb2_out.dep;
      sb3_in.det_zero  = sb2_out.det_zero;
      sb3_in.dep_zero  = sb2_out.dep_zero;
      sb3_in.center    = clamp21(33'(center32));
      sb3_in.side      = (d2_s_ovf || d2_s_q > 33'd32767) ? 16'd65534 : {d2_s_q[14:0], 1'b0};
      sb3_in.first     = '0;
      sb3_in.last      = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else if (adv) begin
         v8_ff <= d2_valid;
      end
   end

   // First and last columns travel with the step divide
   ssp_sb3_type sb3_fwd;
   always_ff @(posedge clock) begin
      if (adv) begin
         sb3_ff <= sb3_in;
      end
   end

   always_comb begin
      sb3_fwd       = sb3_ff;
      sb3_fwd.first = clamp21(33'(sb3_ff.center) - 33'({1'b0, sb3_ff.side[15:1]}));
      sb3_fwd.last  = clamp21(33'(sb3_ff.center) + 33'({1'b0, sb3_ff.side[15:1]}));
   end

   logic              d3_valid, d3_ovf;
   logic [QUO_W-1:0]  d3_q;
   logic [SIDE_W-1:0] d3_side;

   ssp_div u_div_step (
      .clock (clock), .reset (reset), .adv (adv),
      .in_valid (v8_ff), .in_num (NUM_W'(TEX_Q16)), .in_den (DEN_W'(sb3_ff.side)),
      .in_side (SIDE_W'(sb3_fwd)),
      .out_valid (d3_valid), .out_quo (d3_q), .out_ovf (d3_ovf), .out_side (d3_side)
   );

   assign sb3_out = ssp_sb3_type'(d3_side[$bits(ssp_sb3_type)-1:0]);

   // Result register
   logic signed [31:0] lat_ff, dep_ff;
   logic signed [20:0] center_ff, first_ff, last_ff;
   logic        [15:0] side_ff;
   logic        [23:0] step_ff, step_in;
   logic               invalid_ff;

   assign step_in = (sb3_out.side == 16'd0 || d3_ovf || d3_q > 33'h0_00ff_ffff) ?
                    24'hffffff : d3_q[23:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= d3_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (sb3_out.det_zero) begin
            lat_ff     <= '0;
            dep_ff     <= '0;
            center_ff  <= '0;
            side_ff    <= '0;
            first_ff   <= '0;
            last_ff    <= '0;
            step_ff    <= '0;
            invalid_ff <= 1'b1;
         end else if (sb3_out.dep_zero) begin
            lat_ff     <= sb3_out.lat;
            dep_ff     <= sb3_out.dep;
            center_ff  <= '0;
            side_ff    <= '0;
            first_ff   <= '0;
            last_ff    <= '0;
            step_ff    <= '0;
            invalid_ff <= 1'b1;
         end else begin
            lat_ff     <= sb3_out.lat;
            dep_ff     <= sb3_out.dep;
            center_ff  <= sb3_out.center;
            side_ff    <= sb3_out.side;
            first_ff   <= sb3_out.first;
            last_ff    <= sb3_out.last;
            step_ff    <= step_in;
            invalid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cam_lateral = lat_ff;
   assign rsp_cam_depth   = dep_ff;
   assign rsp_center_col  = center_ff;
   assign rsp_side_length = side_ff;
   assign rsp_first_col   = first_ff;
   assign rsp_last_col    = last_ff;
   assign rsp_texel_step  = step_ff;
   assign rsp_invalid     = invalid_ff;

   // Checks
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_side_even: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_side_length[0])
      else $error("odd side length");

   a_lat_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_invalid |-> rsp_cam_lateral != 32'sd0)
      else $error("zero lateral on a valid result");

   a_step_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_invalid && rsp_side_length == 16'd0 |-> rsp_texel_step == 24'hffffff)
      else $error("texel step not saturated for zero side");

endmodule

>>> tb/sv/tb_sprite_screen_projection_top.sv
// Self-checking testbench for the sprite screen projection pipeline.
module tb_sprite_screen_projection_top;
   import ssp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY   = 110;
   localparam int N_RANDOM  = 1800;
   localparam int CYCLE_MAX = 400000;

   typedef struct packed {
      logic signed [31:0] lateral;
      logic signed [31:0] depth;
      logic signed [20:0] center;
      logic        [15:0] side;
      logic signed [20:0] first;
      logic signed [20:0] last;
      logic        [23:0] step;
      logic               invalid;
   } projection_type;

   typedef struct {
      logic [23:0]    sx;
      logic [23:0]    sy;
      logic           typed;
      projection_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [23:0] req_sprite_x = '0;
   logic [23:0] req_sprite_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_cam_lateral, rsp_cam_depth;
   logic signed [20:0] rsp_center_col, rsp_first_col, rsp_last_col;
   logic [15:0] rsp_side_length;
   logic [23:0] rsp_texel_step;
   logic rsp_invalid;
   logic csr_wr_en = 1'b0;
   logic [2:0] csr_index = '0;
   logic [23:0] csr_wdata = '0;

   ssp_cfg_type cfg;
   projection_type projection_q[$];
   projection_type typed_q[$];
   bit typed_flag_q[$];
   int errors = 0;
   int cycles = 0;
   int hold_off = 0;

   sprite_screen_projection_top u_top (.*);

   // Clock and cycle limit
   initial begin
      forever begin
         #5 clock = ~clock;
         if (clock) begin
            cycles++;
            if (cycles > CYCLE_MAX) begin
               $display("CHECK FAILED");
               $finish;
            end
         end
      end
   end

   function automatic longint sat_signed(input longint v, input int w);
      longint hi, lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      return (v > hi) ? hi : ((v < lo) ? lo : v);
   endfunction

   // Project one sprite position through the current camera
   function automatic projection_type project_sprite(input logic [23:0] sx,
                                                     input logic [23:0] sy);
      projection_type p;
      longint dx, dy, dirx, diry, plx, ply, det, lat, dep, adep;
      longint half, height, center, side, step;
      p = '0;
      dirx = longint'(cfg.view_dir_x);
      diry = longint'(cfg.view_dir_y);
      plx = longint'(cfg.cam_plane_x);
      ply = longint'(cfg.cam_plane_y);
      half = longint'({1'b0, cfg.screen_width}) / 2;
      height = longint'({1'b0, cfg.screen_height});
      dx = longint'({1'b0, sx}) - longint'({1'b0, cfg.player_x});
      dy = longint'({1'b0, sy}) - longint'({1'b0, cfg.player_y});
      det = plx * diry - dirx * ply;
      if (det == 0) begin
         p.invalid = 1'b1;
         return p;
      end
      lat = sat_signed(((diry * dx - dirx * dy) * 65536) / det, 32);
      dep = sat_signed(((plx * dy - ply * dx) * 65536) / det, 32);
      if (lat == 0) lat = 66;
      p.lateral = 32'(lat);
      p.depth = 32'(dep);
      if (dep == 0) begin
         p.invalid = 1'b1;
         return p;
      end
      center = sat_signed(((dep + lat) * half) / dep, 21);
      adep = (dep < 0) ? -dep : dep;
      side = ((height * 65536) / (2 * adep)) * 2;
      if (side > 65534) side = 65534;
      if (side == 0) step = 24'hffffff;
      else begin
         step = (longint'(TEX_SIZE) * 65536) / side;
         if (step > 24'hffffff) step = 24'hffffff;
      end
      p.center = 21'(center);
      p.side = 16'(side);
      p.first = 21'(sat_signed(center - side / 2, 21));
      p.last = 21'(sat_signed(center + side / 2, 21));
      p.step = 24'(step);
      return p;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [23:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_PLAYER_X:    cfg.player_x = val;
         CSR_PLAYER_Y:    cfg.player_y = val;
         CSR_VIEW_DIR_X:  cfg.view_dir_x = val[17:0];
         CSR_VIEW_DIR_Y:  cfg.view_dir_y = val[17:0];
         CSR_CAM_PLANE_X: cfg.cam_plane_x = val[17:0];
         CSR_CAM_PLANE_Y: cfg.cam_plane_y = val[17:0];
         CSR_SCREEN_W:    cfg.screen_width = val[12:0];
         default:         cfg.screen_height = val[12:0];
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Drop the request and wait for the pipeline to drain before touching registers
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (projection_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   // Offer one sprite and hold it until the transfer
   task automatic send_sprite(input logic [23:0] sx, input logic [23:0] sy,
                              input bit typed, input projection_type want);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sprite_x <= sx;
      req_sprite_y <= sy;
      projection_q.push_back(project_sprite(sx, sy));
      typed_q.push_back(want);
      typed_flag_q.push_back(typed);
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic logic signed [17:0] rand_vec();
      case ($urandom_range(0, 5))
         0: return 18'sh1ffff;
         1: return -18'sh20000;
         2: return 18'sd0;
         default: return 18'($urandom);
      endcase
   endfunction

   function automatic logic [23:0] rand_pos();
      case ($urandom_range(0, 7))
         0: return 24'hffffff;
         1: return 24'h0;
         2: return cfg.player_x + 24'($urandom_range(0, 3));
         default: return 24'($urandom);
      endcase
   endfunction

   // Receiver: random stalls plus random long hold-offs
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off > 0) begin
            hold_off--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 15) == 0) begin
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 99) == 0) begin
            hold_off = $urandom_range(10, 60);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Check every transferred result against the oldest prediction, or its typed expectation
   always @(posedge clock) begin
      projection_type want, got;
      bit typed;
      projection_type tw;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_cam_lateral, rsp_cam_depth, rsp_center_col, rsp_side_length,
                 rsp_first_col, rsp_last_col, rsp_texel_step, rsp_invalid};
         if (projection_q.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            want = projection_q.pop_front();
            tw = typed_q.pop_front();
            typed = typed_flag_q.pop_front();
            if (typed) want = tw;
            if (got.lateral !== want.lateral) report_mismatch("lateral", got.lateral, want.lateral);
            if (got.depth !== want.depth) report_mismatch("depth", got.depth, want.depth);
            if (got.center !== want.center) report_mismatch("center", got.center, want.center);
            if (got.side !== want.side) report_mismatch("side", got.side, want.side);
            if (got.first !== want.first) report_mismatch("first", got.first, want.first);
            if (got.last !== want.last) report_mismatch("last", got.last, want.last);
            if (got.step !== want.step) report_mismatch("step", got.step, want.step);
            if (got.invalid !== want.invalid)
               report_mismatch("invalid", got.invalid, want.invalid);
         end
      end
   end

   // Stimulus
   initial begin
      stim_row_type rows[$];
      projection_type none, zero_det;
      int n;
      none = '0;
      zero_det = '0;
      zero_det.invalid = 1'b1;
      cfg = '{24'd0, 24'd0, 18'sd65536, 18'sd0, 18'sd0, 18'sd43691, 13'd640, 13'd480};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed pass under the reset camera
      rows.push_back('{24'h0, 24'h0, 1'b1, '{32'sd66, 32'sd0, 21'sd0, 16'd0, 21'sd0,
                                             21'sd0, 24'd0, 1'b1}});
      rows.push_back('{24'hffffff, 24'hffffff, 1'b0, none});
      rows.push_back('{24'hffffff, 24'h0, 1'b0, none});
      rows.push_back('{24'h0, 24'hffffff, 1'b0, none});
      rows.push_back('{24'h010000, 24'h0, 1'b0, none});
      rows.push_back('{24'h000001, 24'h0, 1'b0, none});
      rows.push_back('{24'h0a0000, 24'h030000, 1'b0, none});
      rows.push_back('{24'haaaaaa, 24'h555555, 1'b0, none});
      rows.push_back('{24'h555555, 24'haaaaaa, 1'b0, none});
      foreach (rows[i]) send_sprite(rows[i].sx, rows[i].sy, rows[i].typed, rows[i].want);
      wait_drained();

      // Zero determinant: direction and plane parallel
      write_csr(CSR_CAM_PLANE_Y, 24'd0);
      rows.delete();
      rows.push_back('{24'h123456, 24'h654321, 1'b1, zero_det});
      rows.push_back('{24'hffffff, 24'h0, 1'b1, zero_det});
      foreach (rows[i]) send_sprite(rows[i].sx, rows[i].sy, rows[i].typed, rows[i].want);
      wait_drained();

      // Extreme registers, zero width and tiny height, then large width and height
      write_csr(CSR_PLAYER_X, 24'hffffff);
      write_csr(CSR_PLAYER_Y, 24'h800000);
      write_csr(CSR_VIEW_DIR_X, 24'h020000);
      write_csr(CSR_VIEW_DIR_Y, 24'h01ffff);
      write_csr(CSR_CAM_PLANE_X, 24'h01ffff);
      write_csr(CSR_CAM_PLANE_Y, 24'h000001);
      write_csr(CSR_SCREEN_W, 24'd0);
      write_csr(CSR_SCREEN_H, 24'd1);
      for (int i = 0; i < 6; i++)
         send_sprite(rand_pos(), rand_pos(), 1'b0, none);
      wait_drained();
      write_csr(CSR_SCREEN_W, 24'd4096);
      write_csr(CSR_SCREEN_H, 24'd4096);
      write_csr(CSR_SCREEN_W, 24'h1fff);
      for (int i = 0; i < 6; i++)
         send_sprite(rand_pos(), rand_pos(), 1'b0, none);
      wait_drained();

      // Long receiver hold-off while the sender keeps offering
      hold_off = 400;
      for (int i = 0; i < 150; i++) send_sprite(rand_pos(), rand_pos(), 1'b0, none);

      // Random phases, each with a fresh camera
      n = 0;
      while (n < N_RANDOM) begin
         wait_drained();
         write_csr(CSR_PLAYER_X, 24'($urandom));
         write_csr(CSR_PLAYER_Y, 24'($urandom));
         write_csr(CSR_VIEW_DIR_X, 24'(rand_vec()));
         write_csr(CSR_VIEW_DIR_Y, 24'(rand_vec()));
         write_csr(CSR_CAM_PLANE_X, 24'(rand_vec()));
         write_csr(CSR_CAM_PLANE_Y, 24'(rand_vec()));
         write_csr(CSR_SCREEN_W, 24'($urandom_range(0, 4096)));
         write_csr(CSR_SCREEN_H, 24'($urandom_range(0, 8191)));
         for (int i = 0; i < 100; i++) begin
            send_sprite(rand_pos(), rand_pos(), 1'b0, none);
            n++;
         end
      end
      req_valid <= 1'b0;

      while (projection_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0 && projection_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
